[rtl/bss_pkg.sv]
// Shared types and codes for the bounded stack with search.
// Holds payload structs, operation and status codes and the control
// bundles passed between the controller and the datapath. No dependencies.
package bss_pkg;

    localparam int MODE_W  = 3;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int CNT_W   = 7;

    localparam logic [MODE_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] OP_POP    = 3'd1;
    localparam logic [MODE_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [MODE_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [MODE_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [WORD_W-1:0] value;
    } bss_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] read_value;
        logic [POS_W-1:0]         position;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
    } bss_out_t;

    // controller -> datapath
    typedef struct packed {
        logic              accept;    // input transfer this cycle
        logic              push;      // write top and grow
        logic              pop;       // shrink
        logic              clear;     // drop all entries
        logic              rd_top;    // read top entry, start a walk
        logic              rd_next;   // read next entry down
        logic              done;      // load the result register
        logic [STAT_W-1:0] status;
        logic              use_rdata; // result carries the read word
        logic              use_dist;  // result carries the walk distance
    } bss_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic idx_zero;
        logic out_free;
    } bss_stat_t;

endpackage

[rtl/bss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bss_ctrl.sv]
// Controller for the bounded stack: decodes the operation at the input
// transfer and sequences peek reads and top-down search walks.
// Depends on bss_pkg.
module bss_ctrl
    import bss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [MODE_W-1:0] s_mode,
    input  bss_stat_t         stat,
    output bss_cmd_t          cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_PEEK   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // hold off input transfers while in reset
    assign s_ready = aresetn && (state_reg == S_IDLE) && stat.out_free;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.accept = 1'b1;
                    case (s_mode)
                        OP_PUSH: begin
                            cmd.done = 1'b1;
                            if (stat.full) begin
                                cmd.status = ST_OVERFLOW;
                            end else begin
                                cmd.push   = 1'b1;
                                cmd.status = ST_OK;
                            end
                        end
                        OP_POP: begin
                            cmd.done = 1'b1;
                            if (stat.empty) begin
                                cmd.status = ST_EMPTY;
                            end else begin
                                cmd.pop    = 1'b1;
                                cmd.status = ST_OK;
                            end
                        end
                        OP_PEEK: begin
                            if (stat.empty) begin
                                cmd.done   = 1'b1;
                                cmd.status = ST_EMPTY;
                            end else begin
                                cmd.rd_top = 1'b1;
                                state_next = S_PEEK;
                            end
                        end
                        OP_SEARCH: begin
                            if (stat.empty) begin
                                cmd.done   = 1'b1;
                                cmd.status = ST_NOTFOUND;
                            end else begin
                                cmd.rd_top = 1'b1;
                                state_next = S_SEARCH;
                            end
                        end
                        OP_CLEAR: begin
                            cmd.clear  = 1'b1;
                            cmd.done   = 1'b1;
                            cmd.status = ST_OK;
                        end
                        default: begin
                            cmd.done   = 1'b1;
                            cmd.status = ST_OK;
                        end
                    endcase
                end
            end
            S_PEEK: begin
                cmd.done      = 1'b1;
                cmd.use_rdata = 1'b1;
                cmd.status    = ST_OK;
                state_next    = S_IDLE;
            end
            S_SEARCH: begin
                if (stat.match) begin
                    cmd.done     = 1'b1;
                    cmd.use_dist = 1'b1;
                    cmd.status   = ST_OK;
                    state_next   = S_IDLE;
                end else if (stat.idx_zero) begin
                    cmd.done   = 1'b1;
                    cmd.status = ST_NOTFOUND;
                    state_next = S_IDLE;
                end else begin
                    cmd.rd_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_walk_enters_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_top |=> (state_reg == S_PEEK || state_reg == S_SEARCH))
        else $error("read of top did not start a peek or search");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !cmd.accept)
        else $error("input transfer while an operation is in progress");

    a_one_stack_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.push, cmd.pop, cmd.clear, cmd.rd_top, cmd.rd_next}) <= 1)
        else $error("more than one stack update in a cycle");

endmodule

[rtl/bss_dp.sv]
// Datapath for the bounded stack: entry count, stack RAM, search walk
// registers and the result register. Depends on bss_pkg and bss_ram.
module bss_dp
    import bss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  bss_in_t   s_payload,
    input  bss_cmd_t  cmd,
    output bss_stat_t stat,
    output logic      m_valid,
    input  logic      m_ready,
    output bss_out_t  m_payload
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     idx_reg;
    logic [AW-1:0]     dist_reg;
    logic [WORD_W-1:0] key_reg;
    logic              m_valid_reg;
    bss_out_t          m_payload_reg;
    bss_out_t          res;

    logic [AW-1:0]     top_addr;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rdata;
    logic [POS_W+AW-1:0] pos_wide;
    logic [CNT_W+CW-1:0] cnt_wide;

    assign top_addr = AW'(count_reg - CW'(1));
    assign rd_addr  = cmd.rd_top ? top_addr : (idx_reg - AW'(1));

    bss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (AW'(count_reg)),
        .wdata (s_payload.value),
        .re    (cmd.rd_top || cmd.rd_next),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.push) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.match    = (rdata == key_reg);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = !m_valid_reg || m_ready;

    // report position and count at their fixed field widths
    assign pos_wide = {{POS_W{1'b0}}, (cmd.use_dist ? dist_reg : AW'(0))};
    assign cnt_wide = {{CNT_W{1'b0}}, count_next};

    always_comb begin
        res.status     = cmd.status;
        res.read_value = cmd.use_rdata ? rdata : '0;
        res.position   = pos_wide[POS_W-1:0];
        res.count      = cnt_wide[CNT_W-1:0];
        res.is_empty   = (count_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.done) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_top) begin
            idx_reg  <= top_addr;
            dist_reg <= '0;
            key_reg  <= s_payload.value;
        end else if (cmd.rd_next) begin
            idx_reg  <= idx_reg - AW'(1);
            dist_reg <= dist_reg + AW'(1);
        end
        if (cmd.done) begin
            m_payload_reg <= res;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_no_result_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.done |-> (!m_valid_reg || m_ready))
        else $error("result loaded over an untaken result");

    a_walk_stays_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_next |-> (CW'(idx_reg) < count_reg) && !stat.idx_zero)
        else $error("search walk left the filled entries");

endmodule

[rtl/bounded_stack_with_search_core.sv]
// Bounded LIFO stack of signed 32-bit words with top-down search.
// Input channel s_valid/s_ready carries one operation (push, pop, peek,
// search, clear) and a word in s_payload; each transfer yields exactly one
// result on m_valid/m_ready: status, peeked word, search position, entry
// count after the operation and an empty flag.
// Push, pop, clear and unused codes finish at the input transfer: the result
// is registered there and shows on m_valid the next cycle, and a new item
// may follow every cycle while the receiver takes each result. Peek of a
// non-empty stack reads the top through the registered read of the stack
// RAM; on an empty stack peek and search finish at the input transfer.
// Search walks the RAM from the top one entry per cycle, ending at a match.
// s_ready is high when no operation is in progress and the result register
// is empty or being taken, so a stalled receiver holds one result and
// then stalls the input.
// Reset (aresetn low at a clock edge) empties the stack, drops any
// pending result and holds s_ready low; the RAM contents are not cleared
// and need no sweep. A push to a full stack is dropped with overflow status.
// Depends on bss_pkg, bss_ctrl, bss_dp and bss_ram.
module bounded_stack_with_search_core
    import bss_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bss_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output bss_out_t m_payload
);

    bss_cmd_t  cmd;
    bss_stat_t stat;

    bss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_payload.mode),
        .stat    (stat),
        .cmd     (cmd)
    );

    bss_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

[bench/bounded_stack_with_search_core_test.sv]
// Testbench for bounded_stack_with_search_core: directed and random stack traffic,
// checked transfer by transfer against a behavioral stack predictor.
// Depends on bss_pkg and the core RTL only.
`timescale 1ns / 1ps

module bounded_stack_with_search_core_test;
    import bss_pkg::*;

    localparam int  STACK_DEPTH    = 64;
    localparam int  TAIL_CYCLES    = 2 * STACK_DEPTH + 16;
    localparam int  LONG_STALL     = 300;
    localparam longint WATCHDOG_NS = 64'd20_000_000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    bss_in_t  s_payload;
    logic     m_valid;
    logic     m_ready;
    bss_out_t m_payload;

    // predictor state
    logic [WORD_W-1:0] shadow_words [STACK_DEPTH];
    int                shadow_depth;
    int                peak_depth;

    bss_out_t expected_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_req_len;
    int stall_left;

    int mismatches;
    int ops_sent;
    int results_checked;
    int status_seen [4];

    bounded_stack_with_search_core #(
        .DEPTH(STACK_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("timeout: %0d operations sent, %0d results checked", ops_sent,
                 results_checked);
        $display("CHECK FAILED");
        $finish;
    end

    // Apply one operation to the shadow stack and return the result it must give.
    function automatic bss_out_t stack_apply(input bss_in_t op);
        bss_out_t res;
        bit       hit;
        res        = '0;
        res.status = ST_OK;
        hit        = 1'b0;
        case (op.mode)
            OP_PUSH: begin
                if (shadow_depth >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    shadow_words[shadow_depth] = op.value;
                    shadow_depth++;
                end
            end
            OP_POP: begin
                if (shadow_depth == 0) res.status = ST_EMPTY;
                else shadow_depth--;
            end
            OP_PEEK: begin
                if (shadow_depth == 0) res.status = ST_EMPTY;
                else res.read_value = shadow_words[shadow_depth-1];
            end
            OP_SEARCH: begin
                res.status = ST_NOTFOUND;
                for (int i = shadow_depth - 1; i >= 0; i--) begin
                    if (!hit && shadow_words[i] == op.value) begin
                        hit          = 1'b1;
                        res.status   = ST_OK;
                        res.position = POS_W'(shadow_depth - 1 - i);
                    end
                end
            end
            OP_CLEAR: begin
                shadow_depth = 0;
            end
            default: ;
        endcase
        if (shadow_depth > peak_depth) peak_depth = shadow_depth;
        res.count    = CNT_W'(shadow_depth);
        res.is_empty = (shadow_depth == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic signed [63:0] got,
                                   input logic signed [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch in %s at result %0d: got %0d, want %0d", field,
                     results_checked, got, want);
    endtask

    // Offer one operation and hold it until the input transfer happens.
    task automatic send_op(input logic [MODE_W-1:0] mode, input logic [WORD_W-1:0] value);
        bss_in_t op;
        op.mode  = mode;
        op.value = value;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= op;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(stack_apply(op));
        ops_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (stall_req_len != 0) begin
            stall_left    <= stall_req_len;
            stall_req_len  = 0;
            m_ready       <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_result
        bss_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, status", m_payload.status, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_payload.status !== want.status)
                    report_mismatch("status", m_payload.status, want.status);
                if (m_payload.read_value !== want.read_value)
                    report_mismatch("read_value", m_payload.read_value, want.read_value);
                if (m_payload.position !== want.position)
                    report_mismatch("position", m_payload.position, want.position);
                if (m_payload.count !== want.count)
                    report_mismatch("count", m_payload.count, want.count);
                if (m_payload.is_empty !== want.is_empty)
                    report_mismatch("is_empty", m_payload.is_empty, want.is_empty);
                status_seen[want.status]++;
                results_checked++;
            end
        end
    end

    task automatic test_empty_stack();
        send_op(OP_POP, 32'h0);
        send_op(OP_PEEK, 32'h1234_5678);
        send_op(OP_SEARCH, 32'h0);
        send_op(OP_CLEAR, 32'hFFFF_FFFF);
        // unused codes change nothing
        for (int k = 1; k <= 3; k++) send_op(OP_CLEAR + MODE_W'(k), 32'hA5A5_A5A5);
        drain_results();
    endtask

    task automatic test_extreme_words();
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_PUSH, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 32'h0000_0000);
        send_op(OP_PEEK, 32'h0);
        send_op(OP_SEARCH, 32'h8000_0000);
        send_op(OP_SEARCH, 32'h0000_0000);
        send_op(OP_SEARCH, 32'h5555_5555);
        send_op(OP_POP, 32'h0);
        send_op(OP_PEEK, 32'h0);
        // duplicates: the match nearest the top wins
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_SEARCH, 32'h7FFF_FFFF);
        send_op(OP_POP, 32'h0);
        send_op(OP_SEARCH, 32'h7FFF_FFFF);
        send_op(OP_CLEAR + MODE_W'(2), 32'h0);
        send_op(OP_CLEAR, 32'h0);
        send_op(OP_PEEK, 32'h0);
        drain_results();
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < STACK_DEPTH; i++)
            send_op(OP_PUSH, {i[15:0], ~i[15:0]});
        send_op(OP_PUSH, 32'hDEAD_BEEF);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PEEK, 32'h0);
        send_op(OP_SEARCH, {16'd0, 16'hFFFF});
        send_op(OP_SEARCH, {16'd63, ~16'd63});
        send_op(OP_SEARCH, {16'd20, ~16'd20});
        send_op(OP_SEARCH, 32'hDEAD_BEEF);
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (i % 16 == 0) send_op(OP_PEEK, 32'h0);
            send_op(OP_POP, $urandom);
        end
        send_op(OP_POP, 32'h0);
        send_op(OP_SEARCH, {16'd0, 16'hFFFF});
        drain_results();
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3) return WORD_W'($signed($urandom_range(0, 7)) - 4);
        if (sel == 4) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0;
            endcase
        end
        if (sel <= 6 && shadow_depth != 0)
            return shadow_words[$urandom_range(0, shadow_depth - 1)];
        return $urandom;
    endfunction

    task automatic test_random_mix(input int n_ops, input int send_pct, input int recv_pct);
        int push_bias;
        int roll;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        push_bias     = 50;
        for (int n = 0; n < n_ops; n++) begin
            // swing between filling and emptying so both bounds are reached
            if (n % 128 == 0) push_bias = $urandom_range(15, 85);
            roll = $urandom_range(0, 99);
            if (roll < 2)
                send_op(OP_CLEAR + MODE_W'($urandom_range(1, 3)), $urandom);
            else if (roll < 3)
                send_op(OP_CLEAR, $urandom);
            else if ($urandom_range(0, 99) < push_bias)
                send_op(OP_PUSH, pick_word());
            else begin
                case ($urandom_range(0, 2))
                    0: send_op(OP_POP, $urandom);
                    1: send_op(OP_PEEK, $urandom);
                    default: send_op(OP_SEARCH, pick_word());
                endcase
            end
        end
        drain_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        stall_req_len = LONG_STALL;
        // keep offering while results back up and the input stalls
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 2) send_op(OP_SEARCH, pick_word());
            else send_op(OP_PUSH, pick_word());
        end
        drain_results();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_payload     = '0;
        m_ready       = 1'b0;
        shadow_depth  = 0;
        peak_depth    = 0;
        stall_req_len = 0;
        stall_left    = 0;
        mismatches    = 0;
        ops_sent      = 0;
        results_checked = 0;
        for (int k = 0; k < 4; k++) status_seen[k] = 0;
        send_idle_pct = 12;
        recv_idle_pct = 59;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_stack();
        test_extreme_words();
        test_fill_and_overflow();
        test_random_mix(300, 12, 59);
        test_random_mix(300, 59, 12);
        test_output_backpressure();
        test_random_mix(300, 0, 0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("ran %0d stack operations, %0d results checked, peak depth %0d",
                 ops_sent, results_checked, peak_depth);
        $display("status mix: ok %0d, overflow %0d, empty %0d, not found %0d",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     expected_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
